// ----- hw/rtl/ial_pkg.sv -----
package ial_pkg;

  localparam int CAPACITY = 128;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = 7;
  localparam int CNT_W    = 8;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_UP,
    DP_PUT,
    DP_DOWN,
    DP_DROP,
    DP_FIND,
    DP_HIT,
    DP_READ,
    DP_CATCH,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_FIND,
    S_READ_WAIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    st_en;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  pos_gt;
    logic  pos_ge;
    logic  up_done;
    logic  down_done;
    logic  hit;
    logic  miss_done;
    logic  out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/ial_datapath.sv -----
module ial_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  ial_pkg::dp_cmd_t         cmd,
  output ial_pkg::dp_stat_t        stat,
  input  logic [ial_pkg::KIND_W-1:0] in_kind,
  input  logic [ial_pkg::ADDR_W-1:0] in_position,
  input  logic [ial_pkg::ELEM_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ial_pkg::STAT_W-1:0] out_status,
  output logic [ial_pkg::ADDR_W-1:0] out_found_position,
  output logic [ial_pkg::ELEM_W-1:0] out_read_value,
  output logic [ial_pkg::CNT_W-1:0]  out_length
);

  logic [ial_pkg::ELEM_W-1:0] mem [ial_pkg::CAPACITY];
  logic [ial_pkg::ELEM_W-1:0] rdata;

  ial_pkg::kind_t             kind_q;
  logic [ial_pkg::ADDR_W-1:0] pos_q;
  logic [ial_pkg::ELEM_W-1:0] val_q;
  logic [ial_pkg::CNT_W-1:0]  count;
  logic [ial_pkg::CNT_W-1:0]  ptr;
  logic                       pend;
  logic [ial_pkg::ADDR_W-1:0] pend_addr;
  ial_pkg::status_t           stat_q;
  logic [ial_pkg::ADDR_W-1:0] found_q;
  logic [ial_pkg::ELEM_W-1:0] read_q;

  logic [ial_pkg::CNT_W-1:0]  pos_ext;
  logic                       mem_we;
  logic [ial_pkg::ADDR_W-1:0] mem_waddr;
  logic [ial_pkg::ELEM_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [ial_pkg::ADDR_W-1:0] mem_raddr;
  logic [ial_pkg::CNT_W-1:0]  ptr_dec;
  logic [ial_pkg::CNT_W-1:0]  ptr_inc;

  assign pos_ext = {{(ial_pkg::CNT_W-ial_pkg::ADDR_W){1'b0}}, pos_q};
  assign ptr_dec = ptr - 1'b1;
  assign ptr_inc = ptr + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = rdata;
    mem_re    = 1'b0;
    mem_raddr = ptr[ial_pkg::ADDR_W-1:0];
    case (cmd.op)
      ial_pkg::DP_UP: begin
        mem_we    = pend;
        mem_re    = (ptr > pos_ext);
        mem_raddr = ptr_dec[ial_pkg::ADDR_W-1:0];
      end
      ial_pkg::DP_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
      end
      ial_pkg::DP_DOWN: begin
        mem_we = pend;
        mem_re = (ptr < count);
      end
      ial_pkg::DP_FIND: begin
        mem_re = (ptr < count);
      end
      ial_pkg::DP_READ: begin
        mem_re    = 1'b1;
        mem_raddr = pos_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // request fields and walk state
  always_ff @(posedge clk) begin
    case (cmd.op)
      ial_pkg::DP_LOAD: begin
        kind_q  <= ial_pkg::kind_t'(in_kind);
        pos_q   <= in_position;
        val_q   <= in_value;
        found_q <= '0;
        read_q  <= '0;
        pend    <= 1'b0;
        case (ial_pkg::kind_t'(in_kind))
          ial_pkg::KIND_INSERT: ptr <= count;
          ial_pkg::KIND_DELETE:
            ptr <= {{(ial_pkg::CNT_W-ial_pkg::ADDR_W){1'b0}}, in_position} + 1'b1;
          ial_pkg::KIND_FIND:   ptr <= '0;
          default:              ptr <= {{(ial_pkg::CNT_W-ial_pkg::ADDR_W){1'b0}}, in_position};
        endcase
      end
      ial_pkg::DP_UP: begin
        // move the entry read last cycle up by one, fetch the next lower one
        pend <= mem_re;
        if (mem_re) begin
          pend_addr <= ptr[ial_pkg::ADDR_W-1:0];
          ptr       <= ptr_dec;
        end
      end
      ial_pkg::DP_DOWN: begin
        pend <= mem_re;
        if (mem_re) begin
          pend_addr <= ptr_dec[ial_pkg::ADDR_W-1:0];
          ptr       <= ptr_inc;
        end
      end
      ial_pkg::DP_FIND: begin
        pend <= mem_re;
        if (mem_re) begin
          pend_addr <= ptr[ial_pkg::ADDR_W-1:0];
          ptr       <= ptr_inc;
        end
      end
      ial_pkg::DP_HIT:   found_q <= pend_addr;
      ial_pkg::DP_CATCH: read_q  <= rdata;
      default: begin
      end
    endcase
    if (cmd.st_en) begin
      stat_q <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == ial_pkg::DP_PUT) begin
      count <= count + 1'b1;
    end else if (cmd.op == ial_pkg::DP_DROP) begin
      count <= count - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ial_pkg::DP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ial_pkg::DP_EMIT) begin
      out_status         <= stat_q;
      out_found_position <= found_q;
      out_read_value     <= read_q;
      out_length         <= count;
    end
  end

  always_comb begin
    stat.kind      = kind_q;
    stat.full      = (count == ial_pkg::CNT_W'(ial_pkg::CAPACITY));
    stat.pos_gt    = (pos_ext > count);
    stat.pos_ge    = (pos_ext >= count);
    stat.up_done   = !pend && (ptr == pos_ext);
    stat.down_done = !pend && (ptr >= count);
    stat.hit       = pend && (rdata == val_q);
    stat.miss_done = !pend && (ptr >= count);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- hw/rtl/ial_ctrl.sv -----
module ial_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output ial_pkg::dp_cmd_t  cmd,
  input  ial_pkg::dp_stat_t stat
);

  ial_pkg::state_t state;
  ial_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ial_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ial_pkg::S_IDLE: begin
        if (in_valid) state_next = ial_pkg::S_DECODE;
      end
      ial_pkg::S_DECODE: begin
        case (stat.kind)
          ial_pkg::KIND_INSERT:
            state_next = (stat.full || stat.pos_gt) ? ial_pkg::S_RESULT : ial_pkg::S_SHIFT_UP;
          ial_pkg::KIND_DELETE:
            state_next = stat.pos_ge ? ial_pkg::S_RESULT : ial_pkg::S_SHIFT_DOWN;
          ial_pkg::KIND_FIND:
            state_next = ial_pkg::S_FIND;
          default:
            state_next = stat.pos_ge ? ial_pkg::S_RESULT : ial_pkg::S_READ_WAIT;
        endcase
      end
      ial_pkg::S_SHIFT_UP: begin
        if (stat.up_done) state_next = ial_pkg::S_RESULT;
      end
      ial_pkg::S_SHIFT_DOWN: begin
        if (stat.down_done) state_next = ial_pkg::S_RESULT;
      end
      ial_pkg::S_FIND: begin
        if (stat.hit || stat.miss_done) state_next = ial_pkg::S_RESULT;
      end
      ial_pkg::S_READ_WAIT: begin
        state_next = ial_pkg::S_RESULT;
      end
      ial_pkg::S_RESULT: begin
        if (stat.out_free) state_next = ial_pkg::S_IDLE;
      end
      default: begin
        state_next = ial_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.op    = ial_pkg::DP_NOP;
    cmd.st_en = 1'b0;
    cmd.st    = ial_pkg::ST_OK;
    case (state)
      ial_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = ial_pkg::DP_LOAD;
      end
      ial_pkg::S_DECODE: begin
        cmd.st_en = 1'b1;
        case (stat.kind)
          ial_pkg::KIND_INSERT: begin
            if (stat.full) begin
              cmd.st = ial_pkg::ST_FULL;
            end else if (stat.pos_gt) begin
              cmd.st = ial_pkg::ST_BADPOS;
            end
          end
          ial_pkg::KIND_DELETE: begin
            if (stat.pos_ge) cmd.st = ial_pkg::ST_BADPOS;
          end
          ial_pkg::KIND_FIND: begin
            cmd.st = ial_pkg::ST_NOTFOUND;
          end
          default: begin
            if (stat.pos_ge) begin
              cmd.st = ial_pkg::ST_BADPOS;
            end else begin
              cmd.op = ial_pkg::DP_READ;
            end
          end
        endcase
      end
      ial_pkg::S_SHIFT_UP: begin
        // gap is open at the position once the walk drains: drop the value in
        cmd.op = stat.up_done ? ial_pkg::DP_PUT : ial_pkg::DP_UP;
      end
      ial_pkg::S_SHIFT_DOWN: begin
        cmd.op = stat.down_done ? ial_pkg::DP_DROP : ial_pkg::DP_DOWN;
      end
      ial_pkg::S_FIND: begin
        if (stat.hit) begin
          cmd.op    = ial_pkg::DP_HIT;
          cmd.st_en = 1'b1;
          cmd.st    = ial_pkg::ST_OK;
        end else if (!stat.miss_done) begin
          cmd.op = ial_pkg::DP_FIND;
        end
      end
      ial_pkg::S_READ_WAIT: begin
        cmd.op = ial_pkg::DP_CATCH;
      end
      ial_pkg::S_RESULT: begin
        if (stat.out_free) cmd.op = ial_pkg::DP_EMIT;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/indexed_array_list_unit.sv -----
// Channel   Dir   Word fields (low bit first)
// s_*       in    tuser: kind[1:0]; tdata: position[6:0], value[38:7]
// m_*       out   tdata: status[1:0], found_position[8:2], read_value[40:9],
//                        length[48:41]
//
// One request at a time. Insert and delete take longer the more entries lie
// at or above the position, and find the further in the value lies; a read or
// a refused request needs no walk. The memory walk moves one entry per cycle.
// Reset empties the list at once; the memory is not cleared. A finished word
// waits in the output register while the next request is taken, and a stalled
// m_tready holds the block only when a second result is ready.
module indexed_array_list_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero[39]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // status, found_position, read_value, length, zero
);

  ial_pkg::dp_cmd_t  cmd;
  ial_pkg::dp_stat_t stat;

  logic [ial_pkg::STAT_W-1:0] status;
  logic [ial_pkg::ADDR_W-1:0] found_position;
  logic [ial_pkg::ELEM_W-1:0] read_value;
  logic [ial_pkg::CNT_W-1:0]  length;

  ial_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ial_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (s_tuser),
    .in_position        (s_tdata[6:0]),
    .in_value           (s_tdata[38:7]),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_status         (status),
    .out_found_position (found_position),
    .out_read_value     (read_value),
    .out_length         (length)
  );

  assign m_tdata = {7'd0, length, read_value, found_position, status};

endmodule
